>>> rtl/core/brld_pkg.sv
`timescale 1ns / 1ps

package brld_pkg;

    localparam int DATA_W     = 16;
    localparam int CFG_W      = 17;
    localparam int SUM_W      = 47;
    localparam int NORM_W     = 48;
    localparam int MANT_W     = 32;
    localparam int SHIFT_W    = 6;
    localparam int FRAC_W     = 24;
    localparam int LOG_W      = SHIFT_W + FRAC_W;
    localparam int ITER_W     = 5;
    localparam int PROD_W     = 2 * MANT_W;
    localparam int SCALE_W    = 30;
    localparam int SCALED_W   = LOG_W + SCALE_W;

    localparam logic [CFG_W-1:0]   BLOCK_RST     = 17'd1024;
    localparam logic [ITER_W-1:0]  LOG_ITER_LAST = 5'd23;
    localparam logic [SHIFT_W-1:0] MSB_POS       = 6'd47;
    // 2560 * log10(2) with 20 fraction bits
    localparam logic [SCALE_W-1:0] DB_SCALE_Q20  = 30'd808071242;
    // full scale squared is 2^30
    localparam logic [31:0]        FS_LOG_Q24    = 32'd30 << FRAC_W;
    localparam logic [SCALED_W:0]  ROUND_HALF    = 61'd1 << 43;
    localparam int                 ROUND_SHIFT   = 44;
    localparam logic [16:0]        NEG_LIMIT     = 17'd32768;
    localparam logic [16:0]        POS_LIMIT     = 17'd32767;
    localparam logic [DATA_W-1:0]  LEVEL_MIN     = 16'h8000;
    localparam logic [DATA_W-1:0]  LEVEL_MAX     = 16'h7FFF;

    typedef enum logic [3:0] {
        S_IDLE,
        S_NORM,
        S_SQ,
        S_RN,
        S_NEXT,
        S_DIFF,
        S_MUL,
        S_RND,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic idle;
        logic shift;
        logic sq;
        logic rn;
        logic load_cnt;
        logic diff;
        logic mul;
        logic rnd;
        logic zero;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic blk_done;
        logic norm_msb;
        logic norm_zero;
        logic out_free;
    } t_sts;

endpackage

>>> rtl/core/brld_ctrl.sv
`timescale 1ns / 1ps

module brld_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  brld_pkg::t_sts  i_sts,
    output brld_pkg::t_cmd  o_cmd
);

    brld_pkg::t_state                r_state, n_state;
    logic [brld_pkg::ITER_W-1:0]     r_iter, n_iter;
    logic                            r_phase, n_phase;   // 0: sum, 1: count

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= brld_pkg::S_IDLE;
            r_iter  <= '0;
            r_phase <= 1'b0;
        end else begin
            r_state <= n_state;
            r_iter  <= n_iter;
            r_phase <= n_phase;
        end
    end

    always_comb begin
        n_state = r_state;
        n_iter  = r_iter;
        n_phase = r_phase;
        o_cmd   = '0;
        case (r_state)
            brld_pkg::S_IDLE: begin
                o_cmd.idle = 1'b1;
                if (i_sts.blk_done) begin
                    n_state = brld_pkg::S_NORM;
                    n_phase = 1'b0;
                end
            end
            brld_pkg::S_NORM: begin
                if (!r_phase && i_sts.norm_zero) begin
                    // silent block
                    o_cmd.zero = 1'b1;
                    n_state    = brld_pkg::S_EMIT;
                end else if (i_sts.norm_msb) begin
                    n_iter  = '0;
                    n_state = brld_pkg::S_SQ;
                end else begin
                    o_cmd.shift = 1'b1;
                end
            end
            brld_pkg::S_SQ: begin
                o_cmd.sq = 1'b1;
                n_state  = brld_pkg::S_RN;
            end
            brld_pkg::S_RN: begin
                o_cmd.rn = 1'b1;
                if (r_iter == brld_pkg::LOG_ITER_LAST) begin
                    n_state = r_phase ? brld_pkg::S_DIFF : brld_pkg::S_NEXT;
                end else begin
                    n_iter  = r_iter + 1'b1;
                    n_state = brld_pkg::S_SQ;
                end
            end
            brld_pkg::S_NEXT: begin
                o_cmd.load_cnt = 1'b1;
                n_phase        = 1'b1;
                n_state        = brld_pkg::S_NORM;
            end
            brld_pkg::S_DIFF: begin
                o_cmd.diff = 1'b1;
                n_state    = brld_pkg::S_MUL;
            end
            brld_pkg::S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = brld_pkg::S_RND;
            end
            brld_pkg::S_RND: begin
                o_cmd.rnd = 1'b1;
                n_state   = brld_pkg::S_EMIT;
            end
            brld_pkg::S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = brld_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = brld_pkg::S_IDLE;
            end
        endcase
    end

    a_zero_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.zero |-> !r_phase)
        else $error("silent level raised on the count log");

    a_sq_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == brld_pkg::S_SQ |-> i_sts.norm_msb)
        else $error("squaring an unnormalised mantissa");

    a_diff_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == brld_pkg::S_DIFF |-> r_phase)
        else $error("difference taken before count log");

    a_iter_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_iter <= brld_pkg::LOG_ITER_LAST)
        else $error("log iteration count out of range");

endmodule

>>> rtl/core/brld_dp.sv
`timescale 1ns / 1ps

module brld_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [brld_pkg::CFG_W-1:0]    i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [brld_pkg::DATA_W-1:0]   i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [brld_pkg::DATA_W-1:0]   o_out_data,
    input  brld_pkg::t_cmd                i_cmd,
    output brld_pkg::t_sts                o_sts
);

    logic [brld_pkg::CFG_W-1:0]    r_block_size;
    logic [brld_pkg::SUM_W-1:0]    r_sum;
    logic [brld_pkg::CFG_W-1:0]    r_cnt;
    logic [brld_pkg::CFG_W-1:0]    r_cnt_snap;
    logic [brld_pkg::NORM_W-1:0]   r_norm;
    logic [brld_pkg::SHIFT_W-1:0]  r_shift;
    logic [brld_pkg::FRAC_W-1:0]   r_frac;
    logic [brld_pkg::LOG_W-1:0]    r_log_a;
    logic [brld_pkg::PROD_W-1:0]   r_prod;
    logic                          r_neg;
    logic [brld_pkg::LOG_W-1:0]    r_mag;
    logic [brld_pkg::DATA_W-1:0]   r_level;
    logic                          r_out_valid;
    logic [brld_pkg::DATA_W-1:0]   r_out_data;

    logic signed [31:0]              w_sq_full;
    logic [brld_pkg::SUM_W-1:0]      w_sum_new;
    logic [brld_pkg::CFG_W-1:0]      w_eff;
    logic [brld_pkg::CFG_W:0]        w_cnt_inc;
    logic                            w_last;
    logic                            w_accept;
    logic [brld_pkg::MANT_W-1:0]     w_mant;
    logic [brld_pkg::LOG_W-1:0]      w_log_b;
    logic [31:0]                     w_diff;
    logic [31:0]                     w_abs;
    logic [brld_pkg::SCALED_W-1:0]   w_scaled;
    logic [brld_pkg::SCALED_W:0]     w_rsum;
    logic [16:0]                     w_q;
    logic [brld_pkg::DATA_W-1:0]     w_level;

    // accumulation side
    assign w_sq_full = $signed(i_in_data) * $signed(i_in_data);
    assign w_sum_new = r_sum + {{(brld_pkg::SUM_W-31){1'b0}}, w_sq_full[30:0]};
    assign w_eff     = (r_block_size == '0) ? {{(brld_pkg::CFG_W-1){1'b0}}, 1'b1}
                                            : r_block_size;
    assign w_cnt_inc = {1'b0, r_cnt} + 1'b1;
    assign w_last    = w_cnt_inc >= {1'b0, w_eff};
    // the closing beat of a block waits until the level unit and output are free
    assign o_in_ready = !w_last || (i_cmd.idle && !r_out_valid);
    assign w_accept   = i_in_valid && o_in_ready;

    // log2 side: mantissa 1.31 sits in the top of the normalising register
    assign w_mant  = r_norm[brld_pkg::NORM_W-1 -: brld_pkg::MANT_W];
    assign w_log_b = {brld_pkg::MSB_POS - r_shift, r_frac};
    assign w_diff  = {2'b00, r_log_a} - {2'b00, w_log_b} - brld_pkg::FS_LOG_Q24;
    assign w_abs   = w_diff[31] ? (~w_diff + 1'b1) : w_diff;
    assign w_scaled = r_mag * brld_pkg::DB_SCALE_Q20;
    assign w_rsum  = {1'b0, r_prod[brld_pkg::SCALED_W-1:0]} + brld_pkg::ROUND_HALF;
    assign w_q     = w_rsum[brld_pkg::ROUND_SHIFT +: 17];

    always_comb begin
        if (r_neg) begin
            w_level = (w_q > brld_pkg::NEG_LIMIT) ? brld_pkg::LEVEL_MIN
                                                  : 16'(~w_q + 1'b1);
        end else begin
            w_level = (w_q > brld_pkg::POS_LIMIT) ? brld_pkg::LEVEL_MAX
                                                  : w_q[brld_pkg::DATA_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_size <= brld_pkg::BLOCK_RST;
            r_sum        <= '0;
            r_cnt        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_block_size <= i_cfg_wdata;
            end
            if (w_accept) begin
                if (w_last) begin
                    r_sum <= '0;
                    r_cnt <= '0;
                end else begin
                    r_sum <= w_sum_new;
                    r_cnt <= w_cnt_inc[brld_pkg::CFG_W-1:0];
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_last) begin
            r_norm     <= {1'b0, w_sum_new};
            r_cnt_snap <= w_cnt_inc[brld_pkg::CFG_W-1:0];
            r_shift    <= '0;
            r_frac     <= '0;
        end else if (i_cmd.load_cnt) begin
            r_log_a <= {brld_pkg::MSB_POS - r_shift, r_frac};
            r_norm  <= {{(brld_pkg::NORM_W-brld_pkg::CFG_W){1'b0}}, r_cnt_snap};
            r_shift <= '0;
            r_frac  <= '0;
        end else if (i_cmd.shift) begin
            r_norm  <= {r_norm[brld_pkg::NORM_W-2:0], 1'b0};
            r_shift <= r_shift + 1'b1;
        end else if (i_cmd.rn) begin
            // square lies in [2^62, 2^64); top bit set means the log bit is one
            if (r_prod[brld_pkg::PROD_W-1]) begin
                r_norm <= {r_prod[63:32], {(brld_pkg::NORM_W-brld_pkg::MANT_W){1'b0}}};
                r_frac <= {r_frac[brld_pkg::FRAC_W-2:0], 1'b1};
            end else begin
                r_norm <= {r_prod[62:31], {(brld_pkg::NORM_W-brld_pkg::MANT_W){1'b0}}};
                r_frac <= {r_frac[brld_pkg::FRAC_W-2:0], 1'b0};
            end
        end
        if (i_cmd.sq) begin
            r_prod <= w_mant * w_mant;
        end else if (i_cmd.mul) begin
            r_prod <= {{(brld_pkg::PROD_W-brld_pkg::SCALED_W){1'b0}}, w_scaled};
        end
        if (i_cmd.diff) begin
            r_neg <= w_diff[31];
            r_mag <= w_abs[brld_pkg::LOG_W-1:0];
        end
        if (i_cmd.zero) begin
            r_level <= '0;
        end else if (i_cmd.rnd) begin
            r_level <= w_level;
        end
        if (i_cmd.emit) begin
            r_out_data <= r_level;
        end
    end

    // closing beat offered with the output register empty; the controller
    // only takes it while idle, which is exactly when it is accepted
    assign o_sts.blk_done  = i_in_valid && w_last && !r_out_valid;
    assign o_sts.norm_msb  = r_norm[brld_pkg::NORM_W-1];
    assign o_sts.norm_zero = (r_norm == '0);
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

>>> rtl/core/block_rms_level_db_unit.sv
`timescale 1ns / 1ps
// Block RMS level meter, result in 1/256 dB relative to full scale.
// Input stream: one signed Q1.15 sample per beat on s_axis_tdata. Its square
// is added to a 47-bit sum.
// After block_size samples (i_cfg_wdata, written with i_cfg_we; 0 acts as 1)
// the sum and count are handed to the level unit and accumulation restarts.
// The level unit forms log2 of sum and of count by normalising (one bit shift
// a cycle) and 24 square-and-renormalise steps on one 32x32 multiplier,
// then scales by 2560*log10(2) and rounds.
// The delay from the closing beat of a block to m_axis_tvalid varies with the
// two normalising searches; a silent block gives a level of 0 without them.
// Beats inside a block flow at one per cycle; the closing beat of the next
// block is held (s_axis_tready low) until the previous level has been
// computed and the output register is empty.
// When the receiver stalls, the level waits in the output register and
// sample beats keep flowing until the next block closes.
// Reset (synchronous, active low) clears sum, count and output valid and
// sets the block size to 1024.
module block_rms_level_db_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [brld_pkg::CFG_W-1:0]    i_cfg_wdata,     // block_size
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [brld_pkg::DATA_W-1:0]   s_axis_tdata,    // [15:0] sample
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [brld_pkg::DATA_W-1:0]   m_axis_tdata     // [15:0] level_db
);

    brld_pkg::t_cmd w_cmd;
    brld_pkg::t_sts w_sts;

    brld_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    brld_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_in_data   (s_axis_tdata),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts)
    );

endmodule
